### rtl/core/rpbt_pkg.sv
`default_nettype none

package rpbt_pkg;

    // Default sizes of the table.
    localparam int unsigned TABLE_ROWS_DEF   = 200;
    localparam int unsigned MAX_PRIORITY_DEF = 14;

    // Fixed constants of the band arithmetic.
    localparam int unsigned BAND_SCALE    = 2000;
    localparam int unsigned BAND_DIVISOR  = 14;
    localparam int unsigned BAND_BOTTOM   = 190;
    localparam int unsigned RESET_HORIZON = 42;
    localparam int unsigned QUERY_LIMIT   = 15;

    localparam int unsigned PRIO_W = 4;
    localparam int unsigned HGT_W  = 16;

    // The band height (d * BAND_SCALE) / BAND_DIVISOR is formed as one product with a
    // rounded-up reciprocal followed by a shift. The shift is wide enough that the result
    // is exact for every 8-bit difference d.
    localparam int unsigned HEIGHT_SHIFT = 24;
    localparam logic [31:0] HEIGHT_MUL   = 32'(64'(BAND_SCALE) *
        (((64'd1 << HEIGHT_SHIFT) + 64'(BAND_DIVISOR) - 64'd1) / 64'(BAND_DIVISOR)));
    localparam int unsigned PROD_W       = 40;

    // Request kinds.
    localparam logic [1:0] KIND_LINEAR = 2'd0;
    localparam logic [1:0] KIND_BAND   = 2'd1;
    localparam logic [1:0] KIND_ROW    = 2'd2;
    localparam logic [1:0] KIND_FIND   = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  horizon;
        logic [7:0]  bottom;
        logic [3:0]  band_index;
        logic [15:0] band_boundary;
        logic [9:0]  row;
        logic [7:0]  priority_query;
    } rpbt_req_t;

    typedef struct packed {
        logic [3:0] row_priority;
        logic [7:0] found_row;
        logic       status;
    } rpbt_resp_t;

endpackage

`default_nettype wire

### rtl/core/rpbt_row_ram.sv
`default_nettype none

module rpbt_row_ram #(
    parameter int unsigned DEPTH = rpbt_pkg::TABLE_ROWS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]          wr_addr,
    input  wire logic [rpbt_pkg::PRIO_W-1:0]       wr_data,
    input  wire logic                              rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]          rd_addr,
    output logic      [rpbt_pkg::PRIO_W-1:0]       rd_data
);
    import rpbt_pkg::*;

    logic [PRIO_W-1:0] mem_reg [DEPTH];
    logic [PRIO_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/core/row_priority_band_table.sv
`default_nettype none

// Row priority band table. The block holds a table giving each of TABLE_ROWS screen rows a
// depth priority from 0 to MAX_PRIORITY, plus a bottom row, and answers one response for
// every request. A linear rebuild (kind 0) refills the whole table as equal bands between a
// horizon and a bottom, or answers status 1 and changes nothing when the bottom is not below
// the horizon. A band load (kind 1) writes rows up to one band boundary; the last band fills
// the rest of the table with MAX_PRIORITY and sets the bottom back to 190. A row lookup
// (kind 2) and a priority search (kind 3) read the table. Requests are handled one at a
// time, and the request channel is not ready while one is at work. In a linear rebuild a
// single compare-and-add unit visits each row once and steps the band count once for each
// band crossed. A band load writes one row per cycle and a priority search reads one row
// per cycle; row lookups and priority searches are both bound by the single read port of
// the table memory. A finished response waits in an output register, so the next request
// can be taken while it has not yet been collected. After reset the block runs the linear
// rebuild for horizon 42 and bottom 190 before it takes its first request.
module row_priority_band_table #(
    parameter int unsigned TABLE_ROWS   = rpbt_pkg::TABLE_ROWS_DEF,
    parameter int unsigned MAX_PRIORITY = rpbt_pkg::MAX_PRIORITY_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire rpbt_pkg::rpbt_req_t  s_req,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output rpbt_pkg::rpbt_resp_t      m_resp
);
    import rpbt_pkg::*;

    // Width of a row address, of a row count that can reach TABLE_ROWS itself, and of the
    // width used when comparing row counts with the 8-bit row fields.
    localparam int unsigned RW    = $clog2(TABLE_ROWS);
    localparam int unsigned CW    = $clog2(TABLE_ROWS + 1);
    localparam int unsigned IW    = (CW > 8) ? CW : 8;
    // The running numerator and threshold of the band count never pass this bound.
    localparam int unsigned ACC_W = $clog2(TABLE_ROWS * BAND_SCALE + 16 * 65536);

    // Sequencer states.
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_HEIGHT = 4'd1;
    localparam logic [3:0] ST_HSET   = 4'd2;
    localparam logic [3:0] ST_LIN    = 4'd3;
    localparam logic [3:0] ST_BLOAD  = 4'd4;
    localparam logic [3:0] ST_BFIN   = 4'd5;
    localparam logic [3:0] ST_LOOK   = 4'd6;
    localparam logic [3:0] ST_LOOKD  = 4'd7;
    localparam logic [3:0] ST_SCAN   = 4'd8;
    localparam logic [3:0] ST_RESP   = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic              init_reg, init_next;
    logic [7:0]        h_reg, h_next;
    logic [7:0]        b_reg, b_next;
    logic [7:0]        bottom_reg, bottom_next;
    logic [CW-1:0]     fill_reg, fill_next;
    logic              m_valid_reg, m_valid_next;

    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [HGT_W-1:0]  height_reg, height_next;
    logic [CW-1:0]     n_reg, n_next;
    logic [ACC_W-1:0]  num_reg, num_next;
    logic [ACC_W-1:0]  thr_reg, thr_next;
    logic [PRIO_W-1:0] q_reg, q_next;
    logic [CW-1:0]     bnd_reg, bnd_next;
    logic [PRIO_W-1:0] band_reg, band_next;
    logic [RW-1:0]     addr_reg, addr_next;
    logic [IW-1:0]     lim_reg, lim_next;
    logic [IW-1:0]     scan_reg, scan_next;
    logic              pend_reg, pend_next;
    logic [IW-1:0]     pend_idx_reg, pend_idx_next;
    logic [PRIO_W-1:0] qry_reg, qry_next;
    rpbt_resp_t        res_reg, res_next;
    rpbt_resp_t        m_resp_reg, m_resp_next;

    logic              wr_en;
    logic [RW-1:0]     wr_addr;
    logic [PRIO_W-1:0] wr_data;
    logic              rd_en;
    logic [RW-1:0]     rd_addr;
    logic [PRIO_W-1:0] rd_data;

    // Values formed from a request as it is accepted.
    logic [CW-1:0]     bnd_clamp;
    logic [9:0]        row_lim;
    logic [RW-1:0]     row_addr;
    logic [IW-1:0]     scan_lim;

    rpbt_row_ram #(
        .DEPTH (TABLE_ROWS)
    ) u_row_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_resp  = m_resp_reg;

    // Band boundaries are clamped to the table size.
    assign bnd_clamp = (s_req.band_boundary > 16'(TABLE_ROWS)) ? CW'(TABLE_ROWS)
                                                                : CW'(s_req.band_boundary);

    // A looked-up row is held above the bottom row, then inside the table.
    always_comb begin
        row_lim = s_req.row;
        if (s_req.row >= 10'(bottom_reg)) begin
            row_lim = (bottom_reg != 8'd0) ? 10'(bottom_reg - 8'd1) : 10'd0;
        end
        row_addr = ({1'b0, row_lim} >= 11'(TABLE_ROWS)) ? RW'(TABLE_ROWS - 1) : RW'(row_lim);
    end

    // The search stops at the bottom row or the end of the table, whichever comes first.
    assign scan_lim = (IW'(bottom_reg) > IW'(TABLE_ROWS)) ? IW'(TABLE_ROWS) : IW'(bottom_reg);

    always_comb begin
        state_next    = state_reg;
        init_next     = init_reg;
        h_next        = h_reg;
        b_next        = b_reg;
        bottom_next   = bottom_reg;
        fill_next     = fill_reg;
        prod_next     = prod_reg;
        height_next   = height_reg;
        n_next        = n_reg;
        num_next      = num_reg;
        thr_next      = thr_reg;
        q_next        = q_reg;
        bnd_next      = bnd_reg;
        band_next     = band_reg;
        addr_next     = addr_reg;
        lim_next      = lim_reg;
        scan_next     = scan_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        qry_next      = qry_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_resp_next   = m_resp_reg;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = '0;
        rd_en         = 1'b0;
        rd_addr       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    res_next = '0;
                    unique case (s_req.kind)
                        KIND_LINEAR: begin
                            if (s_req.bottom <= s_req.horizon) begin
                                res_next.status = 1'b1;
                                state_next      = ST_RESP;
                            end else begin
                                h_next     = s_req.horizon;
                                b_next     = s_req.bottom;
                                state_next = ST_HEIGHT;
                            end
                        end
                        KIND_BAND: begin
                            if (s_req.band_index > PRIO_W'(MAX_PRIORITY - 1)) begin
                                state_next = ST_RESP;
                            end else begin
                                bnd_next   = bnd_clamp;
                                band_next  = s_req.band_index;
                                state_next = ST_BLOAD;
                            end
                        end
                        KIND_ROW: begin
                            addr_next  = row_addr;
                            state_next = ST_LOOK;
                        end
                        KIND_FIND: begin
                            if (s_req.priority_query >= 8'(QUERY_LIMIT)) begin
                                res_next.found_row = bottom_reg;
                                state_next         = ST_RESP;
                            end else begin
                                qry_next   = PRIO_W'(s_req.priority_query);
                                lim_next   = scan_lim;
                                scan_next  = '0;
                                pend_next  = 1'b0;
                                state_next = ST_SCAN;
                            end
                        end
                    endcase
                end
            end

            // The band height is one constant product, registered before its use.
            ST_HEIGHT: begin
                prod_next  = PROD_W'(b_reg - h_reg) * PROD_W'(HEIGHT_MUL);
                state_next = ST_HSET;
            end

            ST_HSET: begin
                height_next = prod_reg[HEIGHT_SHIFT +: HGT_W];
                thr_next    = ACC_W'(prod_reg[HEIGHT_SHIFT +: HGT_W]);
                num_next    = '0;
                q_next      = '0;
                n_next      = '0;
                state_next  = ST_LIN;
            end

            // At or past the horizon the band count is raised while the row's numerator
            // reaches the next band threshold, until it saturates; else one row per cycle.
            ST_LIN: begin
                priority if (n_reg == CW'(TABLE_ROWS)) begin
                    bottom_next = b_reg;
                    fill_next   = '0;
                    init_next   = 1'b0;
                    state_next  = init_reg ? ST_IDLE : ST_RESP;
                end else if (IW'(n_reg) < IW'(h_reg)) begin
                    wr_en   = 1'b1;
                    wr_addr = RW'(n_reg);
                    wr_data = '0;
                    n_next  = n_reg + CW'(1);
                end else if ((num_reg >= thr_reg) && (q_reg < PRIO_W'(MAX_PRIORITY - 1))) begin
                    q_next   = q_reg + PRIO_W'(1);
                    thr_next = thr_reg + ACC_W'(height_reg);
                end else begin
                    wr_en    = 1'b1;
                    wr_addr  = RW'(n_reg);
                    wr_data  = q_reg + PRIO_W'(1);
                    n_next   = n_reg + CW'(1);
                    num_next = num_reg + ACC_W'(BAND_SCALE);
                end
            end

            ST_BLOAD: begin
                priority if (fill_reg < bnd_reg) begin
                    wr_en     = 1'b1;
                    wr_addr   = RW'(fill_reg);
                    wr_data   = band_reg;
                    fill_next = fill_reg + CW'(1);
                end else if (band_reg == PRIO_W'(MAX_PRIORITY - 1)) begin
                    state_next = ST_BFIN;
                end else begin
                    state_next = ST_RESP;
                end
            end

            // The last band closes the table with the top priority.
            ST_BFIN: begin
                if (fill_reg < CW'(TABLE_ROWS)) begin
                    wr_en     = 1'b1;
                    wr_addr   = RW'(fill_reg);
                    wr_data   = PRIO_W'(MAX_PRIORITY);
                    fill_next = fill_reg + CW'(1);
                end else begin
                    fill_next   = '0;
                    bottom_next = 8'(BAND_BOTTOM);
                    state_next  = ST_RESP;
                end
            end

            ST_LOOK: begin
                rd_en      = 1'b1;
                rd_addr    = addr_reg;
                state_next = ST_LOOKD;
            end

            ST_LOOKD: begin
                res_next.row_priority = rd_data;
                state_next            = ST_RESP;
            end

            // Reads run one row ahead of the compare; the data of the row read in the
            // previous cycle is checked while the next row is read.
            ST_SCAN: begin
                priority if (pend_reg && (rd_data >= qry_reg)) begin
                    res_next.found_row = 8'(pend_idx_reg);
                    pend_next          = 1'b0;
                    state_next         = ST_RESP;
                end else if (scan_reg < lim_reg) begin
                    rd_en         = 1'b1;
                    rd_addr       = RW'(scan_reg);
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg;
                    scan_next     = scan_reg + IW'(1);
                end else if (pend_reg) begin
                    pend_next = 1'b0;
                end else begin
                    res_next.found_row = bottom_reg;
                    state_next         = ST_RESP;
                end
            end

            // The response moves to the output register once that register is free.
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_resp_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_HEIGHT;
            init_reg    <= 1'b1;
            h_reg       <= 8'(RESET_HORIZON);
            b_reg       <= 8'(BAND_BOTTOM);
            bottom_reg  <= 8'(BAND_BOTTOM);
            fill_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            init_reg    <= init_next;
            h_reg       <= h_next;
            b_reg       <= b_next;
            bottom_reg  <= bottom_next;
            fill_reg    <= fill_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg     <= prod_next;
        height_reg   <= height_next;
        n_reg        <= n_next;
        num_reg      <= num_next;
        thr_reg      <= thr_next;
        q_reg        <= q_next;
        bnd_reg      <= bnd_next;
        band_reg     <= band_next;
        addr_reg     <= addr_next;
        lim_reg      <= lim_next;
        scan_reg     <= scan_next;
        pend_idx_reg <= pend_idx_next;
        qry_reg      <= qry_next;
        res_reg      <= res_next;
        m_resp_reg   <= m_resp_next;
    end

`ifndef SYNTHESIS
    // A response leaving the sequencer always lands in the output register.
    a_resp_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESP && (!m_valid_reg || m_ready)) |=> m_valid_reg)
        else $error("response was not loaded into the output register");

    // No request is taken while the table is still being built after reset.
    a_init_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        init_reg |-> !s_ready)
        else $error("request accepted during the initial table build");

    // A row awaiting its compare always lies inside the search range.
    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && pend_reg) |-> (pend_idx_reg < lim_reg))
        else $error("search compared a row outside its range");

    // An accepted row lookup goes straight to its table read.
    a_row_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_req.kind == KIND_ROW) |=> (state_reg == ST_LOOK))
        else $error("row lookup did not start its table read");
`endif

endmodule

`default_nettype wire

### verif/row_priority_band_table_tb.sv
`timescale 1ns / 100ps

module row_priority_band_table_tb;
    import rpbt_pkg::*;

    localparam int unsigned ROWS         = TABLE_ROWS_DEF;
    localparam int unsigned TOP_PRIO     = MAX_PRIORITY_DEF;
    localparam int unsigned ITEM_TARGET  = 1050;
    // A long receiver hold-off, well beyond the time the block needs to fill its
    // output register and then back up onto the request channel.
    localparam int unsigned HOLD_CYCLES  = 2000;
    localparam int unsigned HOLD_AFTER   = 300;
    // Drain time, longer than the slowest request (a rebuild or a full scan) takes.
    localparam int unsigned DRAIN_CYCLES = 400;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    rpbt_req_t  s_req   = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    rpbt_resp_t m_resp;

    row_priority_band_table u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_resp  (m_resp)
    );

    // Requests waiting to be offered, and the answers the table is expected to give
    // for requests it has already taken, oldest first.
    rpbt_req_t  request_backlog[$];
    rpbt_resp_t answer_queue[$];
    rpbt_resp_t want_resp;

    int unsigned item_count     = 0;
    int unsigned accepted_count = 0;
    int unsigned fail_count     = 0;
    logic        hold_off       = 1'b0;

    // Our own copy of the table: the priority of every row, the bottom row and the
    // next row that a band load writes.
    logic [3:0]  row_prio[ROWS];
    int unsigned bottom_copy;
    int unsigned fill_row;

    // The clock runs from time zero.
    initial begin
        forever #4 aclk = ~aclk;
    end

    // Refill the whole table as equal bands between a horizon and a bottom. Rows above
    // the horizon keep priority 0, and every later row is given its band number plus
    // one, saturating at the top priority.
    function automatic void rebuild_bands(int unsigned horizon, int unsigned bottom);
        int unsigned height;
        int unsigned p;
        height = ((bottom - horizon) * BAND_SCALE) / BAND_DIVISOR;
        for (int unsigned n = 0; n < ROWS; n++) begin
            p = 0;
            if (n >= horizon && height != 0) begin
                p = ((n - horizon) * BAND_SCALE) / height + 1;
                if (p > TOP_PRIO) begin
                    p = TOP_PRIO;
                end
            end
            row_prio[n] = 4'(p);
        end
        bottom_copy = bottom;
        fill_row    = 0;
    endfunction

    // Apply one request to our copy of the table and work out the answer it must get.
    function automatic rpbt_resp_t band_table_answer(rpbt_req_t req);
        rpbt_resp_t  rsp;
        int unsigned bnd;
        int unsigned r;
        int unsigned lim;
        rsp = '0;
        case (req.kind)
            KIND_LINEAR: begin
                // A bottom that is not below the horizon would give no positive band height,
                // so the rebuild is refused and the table left as it was.
                if (req.bottom <= req.horizon) begin
                    rsp.status = 1'b1;
                end else begin
                    rebuild_bands(req.horizon, req.bottom);
                end
            end
            KIND_BAND: begin
                // Band numbers past the last band are simply ignored.
                if (req.band_index <= TOP_PRIO - 1) begin
                    bnd = (req.band_boundary > ROWS) ? ROWS : req.band_boundary;
                    while (fill_row < bnd) begin
                        row_prio[fill_row] = req.band_index;
                        fill_row++;
                    end
                    // The last band closes the load: the remaining rows take the top
                    // priority and the bottom returns to its fixed row.
                    if (req.band_index == TOP_PRIO - 1) begin
                        while (fill_row < ROWS) begin
                            row_prio[fill_row] = 4'(TOP_PRIO);
                            fill_row++;
                        end
                        bottom_copy = BAND_BOTTOM;
                        fill_row    = 0;
                    end
                end
            end
            KIND_ROW: begin
                r = req.row;
                if (r >= bottom_copy) begin
                    r = (bottom_copy > 0) ? bottom_copy - 1 : 0;
                end
                if (r >= ROWS) begin
                    r = ROWS - 1;
                end
                rsp.row_priority = row_prio[r];
            end
            KIND_FIND: begin
                rsp.found_row = 8'(bottom_copy);
                if (req.priority_query < QUERY_LIMIT) begin
                    lim = (bottom_copy > ROWS) ? ROWS : bottom_copy;
                    for (int unsigned i = 0; i < lim; i++) begin
                        if (row_prio[i] >= req.priority_query) begin
                            rsp.found_row = 8'(i);
                            break;
                        end
                    end
                end
            end
        endcase
        return rsp;
    endfunction

    // Every request starts as random bits in all fields, so that the fields a kind
    // does not use are exercised too; the fields that matter are then set.
    function automatic rpbt_req_t noise_req();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(rpbt_req_t)-1:0];
    endfunction

    // Band loads that the block ignores are not counted towards the item total.
    task automatic push_req(rpbt_req_t req);
        request_backlog.push_back(req);
        if (!(req.kind == KIND_BAND && req.band_index > TOP_PRIO - 1)) begin
            item_count++;
        end
    endtask

    task automatic push_linear(int unsigned horizon, int unsigned bottom);
        rpbt_req_t req;
        req         = noise_req();
        req.kind    = KIND_LINEAR;
        req.horizon = 8'(horizon);
        req.bottom  = 8'(bottom);
        push_req(req);
    endtask

    task automatic push_band(int unsigned index, int unsigned boundary);
        rpbt_req_t req;
        req               = noise_req();
        req.kind          = KIND_BAND;
        req.band_index    = 4'(index);
        req.band_boundary = 16'(boundary);
        push_req(req);
    endtask

    task automatic push_row(int unsigned row);
        rpbt_req_t req;
        req      = noise_req();
        req.kind = KIND_ROW;
        req.row  = 10'(row);
        push_req(req);
    endtask

    task automatic push_find(int unsigned query);
        rpbt_req_t req;
        req                = noise_req();
        req.kind           = KIND_FIND;
        req.priority_query = 8'(query);
        push_req(req);
    endtask

    // A lookup of either sort, mostly within the table but now and then with the full
    // range of the row and query fields.
    task automatic push_lookup();
        if ($urandom_range(1) == 0) begin
            push_row(($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(209));
        end else begin
            push_find(($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(15));
        end
    endtask

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Stimulus and the end of the run. The whole list of requests is built at time
    // zero; the driver then takes them from the backlog one at a time.
    initial begin
        int unsigned sel;
        int unsigned h;
        int unsigned b;
        int unsigned cut;

        rebuild_bands(RESET_HORIZON, BAND_BOTTOM);

        // Directed part. The table after reset is read first, at both ends of the row
        // range and with queries at and beyond the top priority.
        push_row(0);
        push_row(1023);
        push_row(189);
        push_find(0);
        push_find(14);
        push_find(15);
        push_find(255);
        // Two refused rebuilds: equal rows, and a bottom far above the horizon.
        push_linear(100, 100);
        push_linear(255, 0);
        // A bottom beyond the table, so no row reaches the top priority and the search
        // falls through to the bottom row.
        push_linear(0, 255);
        push_row(1023);
        push_find(14);
        push_linear(199, 200);
        push_find(1);
        // Band loads: indexes past the last band, a boundary below the fill row, a
        // boundary clamped to the table size, and the last band closing the load.
        push_band(15, 50);
        push_band(14, 50);
        push_band(0, 10);
        push_band(1, 5);
        push_band(2, 65535);
        push_band(13, 0);
        push_row(150);
        push_find(14);
        // The smallest possible table: a single usable row.
        push_linear(0, 1);
        push_row(5);
        push_find(2);
        push_linear(RESET_HORIZON, BAND_BOTTOM);

        // Random part. Most of it is well-formed band loads in increasing order, which
        // is the only way to reach the later bands, mixed with rebuilds and lookups;
        // the rest is stray band loads and requests made entirely of random bits.
        while (item_count < ITEM_TARGET) begin
            sel = $urandom_range(99);
            if (sel < 40) begin
                push_lookup();
            end else if (sel < 55) begin
                case ($urandom_range(9))
                    0: begin
                        h = $urandom_range(255);
                        b = $urandom_range(h);
                    end
                    1: begin
                        h = $urandom_range(254);
                        b = $urandom_range(255, h + 1);
                    end
                    default: begin
                        h = $urandom_range(199);
                        b = $urandom_range(200, h + 1);
                    end
                endcase
                push_linear(h, b);
            end else if (sel < 70) begin
                cut = 0;
                for (int unsigned i = 0; i < TOP_PRIO; i++) begin
                    case ($urandom_range(29))
                        0:       cut = $urandom_range(65535);
                        1:       cut = cut;
                        default: cut = cut + $urandom_range(25);
                    endcase
                    push_band(i, cut);
                    if ($urandom_range(3) == 0) begin
                        push_lookup();
                    end
                end
            end else if (sel < 80) begin
                push_band($urandom_range(15), ($urandom_range(1) == 0) ?
                          $urandom_range(65535) : $urandom_range(210));
            end else begin
                push_req(noise_req());
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for every request to be taken and every answer to come back, sampling
        // away from the active edge.
        while (request_backlog.size() != 0 || s_valid || answer_queue.size() != 0) begin
            @(negedge aclk);
        end
        // Give the block time to show any result it should not produce.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("row_priority_band_table_tb OK");
        end else begin
            $display("row_priority_band_table_tb NOT OK");
        end
        $finish;
    end

    // Driver. It sends requests in bursts of random length, with random gaps between
    // them. Once a request is offered it is held, unchanged, until the block takes it;
    // the answer is predicted at the edge where the request is accepted.
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                answer_queue.push_back(band_table_answer(s_req));
                accepted_count++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (request_backlog.size() > 0) begin
                    s_valid <= 1'b1;
                    s_req   <= request_backlog.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        // Now and then a long burst with no gaps at all.
                        burst_left = ($urandom_range(4) == 0) ? $urandom_range(150, 40)
                                                              : $urandom_range(12);
                        gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(16, 1);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. It alternates runs of readiness with short stalls, sometimes taking a
    // long run with no stall, and drops ready altogether while the hold-off is on.
    int unsigned ready_run  = 0;
    int unsigned stall_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (ready_run > 0) begin
            ready_run--;
            m_ready <= !hold_off;
        end else begin
            ready_run  = ($urandom_range(3) == 0) ? $urandom_range(400, 100)
                                                  : $urandom_range(30, 1);
            stall_left = $urandom_range(8, 1);
            m_ready <= !hold_off;
        end
    end

    // Back-pressure. After a few hundred requests the receiver holds off for a long
    // stretch while the driver keeps offering, so that the output register fills and
    // the block has to stall its request channel.
    initial begin
        wait (accepted_count >= HOLD_AFTER);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // Monitor. Every answer taken from the block is checked field by field against the
    // oldest prediction still waiting.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (answer_queue.size() == 0) begin
                $error("unexpected response: priority %0d, row %0d, status %0d",
                       m_resp.row_priority, m_resp.found_row, m_resp.status);
                fail_count++;
            end else begin
                want_resp = answer_queue.pop_front();
                compare_field("row_priority", want_resp.row_priority, m_resp.row_priority);
                compare_field("found_row", want_resp.found_row, m_resp.found_row);
                compare_field("status", want_resp.status, m_resp.status);
            end
        end
    end

    // Overall time limit, several times the slowest legal run.
    initial begin
        #10_000_000;
        $display("row_priority_band_table_tb NOT OK");
        $finish;
    end

endmodule

### filelist.f
rtl/core/rpbt_pkg.sv
rtl/core/rpbt_row_ram.sv
rtl/core/row_priority_band_table.sv
verif/row_priority_band_table_tb.sv
